/* hdl/lhf_pkg.sv */
package lhf_pkg;

   // Default sizes for the top level parameters.
   localparam int DEFAULT_LINE_BUFFER_SIZE = 128;
   localparam int DEFAULT_PATTERN_MAX      = 32;

   // Payload and register widths.
   localparam int HANDLE_W        = 16;
   localparam int PROPERTY_W      = 8;
   localparam int BYTE_W          = 8;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int PATTERN_LEN_W   = 6;
   localparam int PATTERN_WORDS   = 4;
   localparam int PATTERN_CHARS   = 32;
   localparam int CHAR_INDEX_W    = 5;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_WORD3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_PROPERTY = 3'd5;

   localparam logic [PATTERN_LEN_W-1:0] PATTERN_LENGTH_RESET = 6'd4;

   // Item kinds.
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Characters the parser reacts to.
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'hFF;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
   localparam logic [BYTE_W-1:0] CHAR_D     = 8'h44;

   // Decodes one hex digit; the top bit flags a character that is no digit.
   function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h61 + 8'd10)};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

endpackage

/* hdl/lhf_channels.sv */
// Input channel: one listing byte or a flush per transfer.
interface lhf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [lhf_pkg::BYTE_W-1:0]       data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one found handle per closed listing.
interface lhf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lhf_pkg::HANDLE_W-1:0]     found_handle;
   logic                             ended_by_end_line;

   modport source (output valid, output found_handle, output ended_by_end_line, input ready);
   modport sink   (input valid, input found_handle, input ended_by_end_line, output ready);
endinterface

/* hdl/listing_line_handle_finder.sv */
// Channel     Direction  Transfer carries
// req_chan    in         kind, data_byte (one listing byte or a flush)
// rsp_chan    out        found_handle, ended_by_end_line (one per listing)
// csr_*       in         register write, index and 64-bit data
//
// The line state is updated from the accepted byte in the same cycle,
// including the two-byte update when a held carriage return goes ahead of it.
// Results go to an output register with a skid stage behind it; req_chan
// stays ready while one result waits and drops only when both are full.
// Synchronous reset clears all but the result data and sets pattern length 4.
module listing_line_handle_finder #(
   parameter int LINE_BUFFER_SIZE = lhf_pkg::DEFAULT_LINE_BUFFER_SIZE,
   parameter int PATTERN_MAX      = lhf_pkg::DEFAULT_PATTERN_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   lhf_req_if.sink                           req_chan,
   lhf_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [lhf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lhf_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int LL_W   = $clog2(LINE_BUFFER_SIZE);
   localparam int CMP_W  = 12;
   localparam int PLEN_W = lhf_pkg::PATTERN_LEN_W;

   typedef struct packed {
      logic [LL_W-1:0]                          line_length;
      logic                                     cr_pending;
      logic [PATTERN_MAX-1:0][lhf_pkg::BYTE_W-1:0] recent;
      logic                                     pattern_seen;
      logic                                     first_comma;
      logic [2:0]                               handle_count;
      logic [lhf_pkg::HANDLE_W-1:0]             handle_value;
      logic                                     handle_invalid;
      logic                                     second_comma;
      logic [1:0]                               prop_count;
      logic [lhf_pkg::PROPERTY_W-1:0]           prop_value;
      logic                                     prop_invalid;
      logic [1:0]                               end_progress;
   } line_state_type;

   typedef logic [PATTERN_MAX-1:0][lhf_pkg::BYTE_W-1:0] window_type;

   // Configuration registers.
   logic [lhf_pkg::PATTERN_WORDS-1:0][lhf_pkg::CSR_DATA_W-1:0] pattern_word_ff;
   logic [PLEN_W-1:0]                pattern_length_ff;
   logic [lhf_pkg::PROPERTY_W-1:0]   target_property_ff;

   // Parser state.
   line_state_type                   state_ff, state_in;
   logic [lhf_pkg::HANDLE_W-1:0]     remembered_ff, remembered_in;

   // Result register and skid stage.
   logic                             rsp_valid_ff;
   logic [lhf_pkg::HANDLE_W-1:0]     rsp_handle_ff;
   logic                             rsp_by_end_ff;
   logic                             skid_valid_ff;
   logic [lhf_pkg::HANDLE_W-1:0]     skid_handle_ff;
   logic                             skid_by_end_ff;

   logic                             accept;
   logic                             produce;
   logic [lhf_pkg::HANDLE_W-1:0]     new_handle;
   logic                             new_by_end;

   logic [PLEN_W-1:0]                plen;
   logic [PATTERN_MAX-1:0]           pat_mask;
   window_type                       pat_expected;
   logic [lhf_pkg::PATTERN_CHARS-1:0][lhf_pkg::BYTE_W-1:0] pattern_bytes;

   // One byte into the line: window shift, pattern check and field capture.
   function automatic line_state_type store_byte(
      input line_state_type              s,
      input logic [lhf_pkg::BYTE_W-1:0]  c,
      input window_type                  expected,
      input logic [PATTERN_MAX-1:0]      mask,
      input logic [PLEN_W-1:0]           len
   );
      line_state_type                n;
      logic                          hit;
      logic [4:0]                    d;
      logic [lhf_pkg::BYTE_W-1:0]    end_char;
      n = s;
      if (s.line_length < LL_W'(LINE_BUFFER_SIZE - 1)) begin
         // Track whether the line so far spells the end word.
         case (s.line_length[1:0])
            2'd0:    end_char = lhf_pkg::CHAR_E;
            2'd1:    end_char = lhf_pkg::CHAR_N;
            default: end_char = lhf_pkg::CHAR_D;
         endcase
         if (s.line_length < LL_W'(3) && LL_W'(s.end_progress) == s.line_length &&
             c == end_char) begin
            n.end_progress = s.end_progress + 2'd1;
         end
         n.recent      = {s.recent[PATTERN_MAX-2:0], c};
         n.line_length = s.line_length + LL_W'(1);
         // Compare the newest bytes against the reversed pattern.
         hit = 1'b1;
         for (int i = 0; i < PATTERN_MAX; i++) begin
            if (mask[i] && n.recent[i] != expected[i]) begin
               hit = 1'b0;
            end
         end
         if (CMP_W'(n.line_length) >= CMP_W'(len) && hit) begin
            n.pattern_seen = 1'b1;
         end
         // Hex fields after the first and second comma.
         d = lhf_pkg::hex_digit(c);
         if (s.second_comma && s.prop_count < 2'd2) begin
            if (d[4]) begin
               n.prop_invalid = 1'b1;
            end else begin
               n.prop_value = {s.prop_value[3:0], d[3:0]};
            end
            n.prop_count = s.prop_count + 2'd1;
         end
         if (s.first_comma && s.handle_count < 3'd4) begin
            if (d[4]) begin
               n.handle_invalid = 1'b1;
            end else begin
               n.handle_value = {s.handle_value[11:0], d[3:0]};
            end
            n.handle_count = s.handle_count + 3'd1;
         end
         if (c == lhf_pkg::CHAR_COMMA) begin
            if (s.first_comma && !s.second_comma) begin
               n.second_comma = 1'b1;
            end else if (!s.first_comma) begin
               n.first_comma = 1'b1;
            end
         end
      end
      return n;
   endfunction

   // End of a line: a complete matching line updates the remembered handle.
   function automatic logic [lhf_pkg::HANDLE_W-1:0] finish_line(
      input line_state_type                  s,
      input logic [lhf_pkg::HANDLE_W-1:0]    rem,
      input logic [lhf_pkg::PROPERTY_W-1:0]  target
   );
      logic [lhf_pkg::HANDLE_W-1:0]   r;
      logic [lhf_pkg::PROPERTY_W-1:0] prop;
      r = rem;
      prop = s.prop_invalid ? '0 : s.prop_value;
      if (s.line_length != '0 && s.pattern_seen && s.first_comma &&
          s.handle_count == 3'd4 && s.second_comma && s.prop_count == 2'd2 &&
          prop == target) begin
         r = s.handle_invalid ? '0 : s.handle_value;
      end
      return r;
   endfunction

   // Pattern aligned to the window: newest byte against the last character.
   assign pattern_bytes = pattern_word_ff;
   assign plen = (pattern_length_ff > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX)
                                                            : pattern_length_ff;

   always_comb begin
      logic [PLEN_W-1:0] k;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         k = plen - PLEN_W'(i) - PLEN_W'(1);
         pat_mask[i]     = PLEN_W'(i) < plen;
         pat_expected[i] = pattern_bytes[k[lhf_pkg::CHAR_INDEX_W-1:0]];
      end
   end

   // Handshake: take items as long as the skid stage is free.
   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && !skid_valid_ff;

   // Per-item parser step.
   always_comb begin
      line_state_type s1;
      logic           is_end;
      state_in      = state_ff;
      remembered_in = remembered_ff;
      produce       = 1'b0;
      new_handle    = remembered_ff;
      new_by_end    = 1'b0;
      s1            = state_ff;
      is_end        = 1'b0;
      if (accept) begin
         if (req_chan.kind == lhf_pkg::KIND_FLUSH) begin
            produce       = 1'b1;
            new_handle    = finish_line(state_ff, remembered_ff, target_property_ff);
            state_in      = '0;
            remembered_in = '0;
         end else if (req_chan.data_byte == lhf_pkg::CHAR_NUL ||
                      req_chan.data_byte == lhf_pkg::CHAR_DEL) begin
            state_in = state_ff;
         end else if (req_chan.data_byte == lhf_pkg::CHAR_CR) begin
            state_in.cr_pending = 1'b1;
         end else if (req_chan.data_byte == lhf_pkg::CHAR_LF && state_ff.cr_pending) begin
            is_end = state_ff.line_length == LL_W'(3) && state_ff.end_progress == 2'd3;
            remembered_in = finish_line(state_ff, remembered_ff, target_property_ff);
            state_in      = '0;
            if (is_end) begin
               produce       = 1'b1;
               new_handle    = remembered_in;
               new_by_end    = 1'b1;
               remembered_in = '0;
            end
         end else begin
            // A held carriage return goes into the line ahead of this byte.
            if (state_ff.cr_pending) begin
               s1 = store_byte(state_ff, lhf_pkg::CHAR_CR, pat_expected, pat_mask, plen);
               s1.cr_pending = 1'b0;
            end
            state_in = store_byte(s1, req_chan.data_byte, pat_expected, pat_mask, plen);
         end
      end
   end

   // Configuration, parser state and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_word_ff    <= '0;
         pattern_length_ff  <= lhf_pkg::PATTERN_LENGTH_RESET;
         target_property_ff <= '0;
         state_ff           <= '0;
         remembered_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               lhf_pkg::REG_PATTERN_WORD0:   pattern_word_ff[0] <= csr_write_data;
               lhf_pkg::REG_PATTERN_WORD1:   pattern_word_ff[1] <= csr_write_data;
               lhf_pkg::REG_PATTERN_WORD2:   pattern_word_ff[2] <= csr_write_data;
               lhf_pkg::REG_PATTERN_WORD3:   pattern_word_ff[3] <= csr_write_data;
               lhf_pkg::REG_PATTERN_LENGTH:  pattern_length_ff <= csr_write_data[PLEN_W-1:0];
               lhf_pkg::REG_TARGET_PROPERTY:
                  target_property_ff <= csr_write_data[lhf_pkg::PROPERTY_W-1:0];
               default: ;
            endcase
         end
         state_ff      <= state_in;
         remembered_ff <= remembered_in;
         // Output register drains first; the skid stage catches a stalled result.
         if (!rsp_valid_ff || rsp_chan.ready) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= produce;
            end
         end else if (produce) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            rsp_handle_ff <= skid_handle_ff;
            rsp_by_end_ff <= skid_by_end_ff;
         end else if (produce) begin
            rsp_handle_ff <= new_handle;
            rsp_by_end_ff <= new_by_end;
         end
      end else if (produce) begin
         skid_handle_ff <= new_handle;
         skid_by_end_ff <= new_by_end;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.found_handle      = rsp_handle_ff;
   assign rsp_chan.ended_by_end_line = rsp_by_end_ff;

endmodule

/* tb/lhf_checker.sv */
module lhf_checker (
   input  logic                            clock,
   input  logic                            reset,
   lhf_req_if                              req,
   lhf_rsp_if                              rsp,
   input  logic                            csr_write_enable,
   input  logic [lhf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lhf_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                              error_count,
   output int                              pending_count,
   output int                              closed_by_end,
   output int                              closed_by_flush,
   output int                              handles_found
);
   timeunit 1ns;
   timeprecision 1ps;

   // Bytes kept per line; later bytes of a long line are dropped.
   localparam int LINE_KEEP = lhf_pkg::DEFAULT_LINE_BUFFER_SIZE - 1;

   typedef struct packed {
      logic [lhf_pkg::HANDLE_W-1:0] found_handle;
      logic                         ended_by_end_line;
   } listing_result_type;

   listing_result_type expected_listings[$];

   // Register copies.
   logic [lhf_pkg::CSR_DATA_W-1:0]    pat_word [lhf_pkg::PATTERN_WORDS];
   logic [lhf_pkg::PATTERN_LEN_W-1:0] pat_len;
   logic [lhf_pkg::PROPERTY_W-1:0]    target_prop;

   // Line scan state.
   int                             line_len;
   bit                             cr_held;
   logic [lhf_pkg::BYTE_W-1:0]     tail [lhf_pkg::PATTERN_CHARS];
   bit                             pat_hit;
   bit                             comma1;
   bit                             comma2;
   int                             handle_digits;
   logic [lhf_pkg::HANDLE_W-1:0]   handle_acc;
   bit                             handle_bad;
   int                             prop_digits;
   logic [lhf_pkg::PROPERTY_W-1:0] prop_acc;
   bit                             prop_bad;
   int                             end_progress;
   logic [lhf_pkg::HANDLE_W-1:0]   kept_handle;

   int errors      = 0;
   int waiting     = 0;
   int end_count   = 0;
   int flush_count = 0;
   int found_count = 0;

   assign error_count     = errors;
   assign pending_count   = waiting;
   assign closed_by_end   = end_count;
   assign closed_by_flush = flush_count;
   assign handles_found   = found_count;

   // Value of a hex digit, or -1 for any other character.
   function automatic int hex_nibble(input logic [lhf_pkg::BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   function automatic logic [lhf_pkg::BYTE_W-1:0] pattern_char(input int k);
      return pat_word[k >> 3][8 * (k & 7) +: 8];
   endfunction

   function automatic void clear_line_state();
      int i;
      line_len      = 0;
      cr_held       = 1'b0;
      for (i = 0; i < lhf_pkg::PATTERN_CHARS; i++) tail[i] = '0;
      pat_hit       = 1'b0;
      comma1        = 1'b0;
      comma2        = 1'b0;
      handle_digits = 0;
      handle_acc    = '0;
      handle_bad    = 1'b0;
      prop_digits   = 0;
      prop_acc      = '0;
      prop_bad      = 1'b0;
      end_progress  = 0;
   endfunction

   // One byte stored into the line: END tracking, pattern window, field digits.
   function automatic void store_line_byte(input logic [lhf_pkg::BYTE_W-1:0] c);
      int i;
      int plen;
      int d;
      bit hit;
      bit f1;
      bit f2;
      logic [lhf_pkg::BYTE_W-1:0] end_char;
      if (line_len >= LINE_KEEP) return;
      if (line_len < 3 && end_progress == line_len) begin
         end_char = (line_len == 0) ? lhf_pkg::CHAR_E :
                    (line_len == 1) ? lhf_pkg::CHAR_N : lhf_pkg::CHAR_D;
         if (c == end_char) end_progress++;
      end
      for (i = lhf_pkg::PATTERN_CHARS - 1; i > 0; i--) tail[i] = tail[i - 1];
      tail[0] = c;
      line_len++;

      plen = (pat_len > lhf_pkg::PATTERN_CHARS) ? lhf_pkg::PATTERN_CHARS : int'(pat_len);
      if (line_len >= plen) begin
         hit = 1'b1;
         for (i = 0; i < plen; i++) begin
            if (pattern_char(plen - 1 - i) != tail[i]) hit = 1'b0;
         end
         if (hit) pat_hit = 1'b1;
      end

      // Both fields look at the flags as they stood before this byte.
      f1 = comma1;
      f2 = comma2;
      d  = hex_nibble(c);
      if (f2 && prop_digits < 2) begin
         if (d < 0) prop_bad = 1'b1;
         else prop_acc = {prop_acc[3:0], 4'(d)};
         prop_digits++;
      end
      if (f1 && handle_digits < 4) begin
         if (d < 0) handle_bad = 1'b1;
         else handle_acc = {handle_acc[11:0], 4'(d)};
         handle_digits++;
      end
      if (c == lhf_pkg::CHAR_COMMA) begin
         if (f1 && !f2) comma2 = 1'b1;
         else if (!f1) comma1 = 1'b1;
      end
   endfunction

   // A complete record whose property hits the target updates the kept handle.
   function automatic void finish_line();
      logic [lhf_pkg::PROPERTY_W-1:0] prop;
      if (line_len == 0) return;
      if (pat_hit && comma1 && handle_digits == 4 && comma2 && prop_digits == 2) begin
         prop = prop_bad ? '0 : prop_acc;
         if (prop == target_prop) kept_handle = handle_bad ? '0 : handle_acc;
      end
   endfunction

   function automatic void close_listing(input bit by_end);
      listing_result_type r;
      r.found_handle      = kept_handle;
      r.ended_by_end_line = by_end;
      expected_listings.push_back(r);
      if (by_end) end_count++;
      else flush_count++;
      if (kept_handle != '0) found_count++;
      clear_line_state();
      kept_handle = '0;
   endfunction

   function automatic void take_item(input logic kind, input logic [lhf_pkg::BYTE_W-1:0] c);
      bit is_end;
      if (kind == lhf_pkg::KIND_FLUSH) begin
         finish_line();
         close_listing(1'b0);
         return;
      end
      if (c == lhf_pkg::CHAR_NUL || c == lhf_pkg::CHAR_DEL) return;
      if (c == lhf_pkg::CHAR_CR) begin
         cr_held = 1'b1;
         return;
      end
      if (c == lhf_pkg::CHAR_LF && cr_held) begin
         is_end = (line_len == 3 && end_progress == 3);
         finish_line();
         if (is_end) close_listing(1'b1);
         else clear_line_state();
         return;
      end
      // A carriage return not followed by line feed is kept as data.
      if (cr_held) begin
         store_line_byte(lhf_pkg::CHAR_CR);
         cr_held = 1'b0;
      end
      store_line_byte(c);
   endfunction

   function automatic void write_setting(input logic [lhf_pkg::CSR_INDEX_W-1:0] index,
                                         input logic [lhf_pkg::CSR_DATA_W-1:0] data);
      case (index)
         lhf_pkg::REG_PATTERN_WORD0:   pat_word[0] = data;
         lhf_pkg::REG_PATTERN_WORD1:   pat_word[1] = data;
         lhf_pkg::REG_PATTERN_WORD2:   pat_word[2] = data;
         lhf_pkg::REG_PATTERN_WORD3:   pat_word[3] = data;
         lhf_pkg::REG_PATTERN_LENGTH:  pat_len = data[lhf_pkg::PATTERN_LEN_W-1:0];
         lhf_pkg::REG_TARGET_PROPERTY: target_prop = data[lhf_pkg::PROPERTY_W-1:0];
         default: ;
      endcase
   endfunction

   // Track every transfer and compare each result with the oldest prediction.
   always @(posedge clock) begin
      listing_result_type want;
      int i;
      if (reset) begin
         for (i = 0; i < lhf_pkg::PATTERN_WORDS; i++) pat_word[i] = '0;
         pat_len     = lhf_pkg::PATTERN_LENGTH_RESET;
         target_prop = '0;
         kept_handle = '0;
         clear_line_state();
         expected_listings.delete();
      end else begin
         if (csr_write_enable) write_setting(csr_index, csr_write_data);
         if (req.valid && req.ready) take_item(req.kind, req.data_byte);
         if (rsp.valid && rsp.ready) begin
            if (expected_listings.size() == 0) begin
               $error("unexpected result: found_handle %h ended_by_end_line %0d",
                      rsp.found_handle, rsp.ended_by_end_line);
               errors++;
            end else begin
               want = expected_listings.pop_front();
               if (rsp.found_handle !== want.found_handle) begin
                  $error("found_handle: expected %h, got %h",
                         want.found_handle, rsp.found_handle);
                  errors++;
               end
               if (rsp.ended_by_end_line !== want.ended_by_end_line) begin
                  $error("ended_by_end_line: expected %0d, got %0d",
                         want.ended_by_end_line, rsp.ended_by_end_line);
                  errors++;
               end
            end
         end
      end
      waiting = expected_listings.size();
   end

endmodule

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT    = 2000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 56;
   localparam int PHASE_LISTINGS = 1;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;

   // Indexes the block does not decode; writes to them must change nothing.
   localparam logic [lhf_pkg::CSR_INDEX_W-1:0] REG_SPARE6 = 3'd6;
   localparam logic [lhf_pkg::CSR_INDEX_W-1:0] REG_SPARE7 = 3'd7;

   typedef logic [lhf_pkg::CSR_DATA_W-1:0] csr_word_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_enable;
   logic [lhf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lhf_pkg::CSR_DATA_W-1:0]  csr_write_data;

   lhf_req_if req_chan ();
   lhf_rsp_if rsp_chan ();

   int chk_errors;
   int chk_pending;
   int chk_end;
   int chk_flush;
   int chk_found;

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int hold_request   = 0;
   int items_sent     = 0;
   int quiet_cycles   = 0;

   // Current pattern text and target, used to build matching records.
   logic [lhf_pkg::BYTE_W-1:0]     pat_chars [lhf_pkg::PATTERN_CHARS];
   int                             pat_use;
   logic [lhf_pkg::PROPERTY_W-1:0] target_now;
   logic [lhf_pkg::BYTE_W-1:0]     line_q [$];

   always #4 clock = ~clock;

   listing_line_handle_finder dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   lhf_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (chk_errors),
      .pending_count    (chk_pending),
      .closed_by_end    (chk_end),
      .closed_by_flush  (chk_flush),
      .handles_found    (chk_found)
   );

   // Watchdog: ends the run after too many cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   function automatic logic [lhf_pkg::BYTE_W-1:0] random_text_char();
      logic [lhf_pkg::BYTE_W-1:0] c;
      do c = 8'($urandom_range(33, 126)); while (c == lhf_pkg::CHAR_COMMA);
      return c;
   endfunction

   function automatic logic [lhf_pkg::BYTE_W-1:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      if ($urandom_range(1) == 0) return "A" + 8'(n) - 8'd10;
      return "a" + 8'(n) - 8'd10;
   endfunction

   function automatic logic [lhf_pkg::BYTE_W-1:0] non_hex_char();
      logic [lhf_pkg::BYTE_W-1:0] c;
      do c = random_text_char();
      while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
      return c;
   endfunction

   // Offers one item with a random lead-in gap and waits for its transfer.
   task automatic send_item(input logic kind, input logic [lhf_pkg::BYTE_W-1:0] value);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.data_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (kind == lhf_pkg::KIND_FLUSH ||
          (value != lhf_pkg::CHAR_NUL && value != lhf_pkg::CHAR_DEL)) items_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_item(lhf_pkg::KIND_BYTE, s[i]);
   endtask

   task automatic send_crlf();
      send_item(lhf_pkg::KIND_BYTE, lhf_pkg::CHAR_CR);
      send_item(lhf_pkg::KIND_BYTE, lhf_pkg::CHAR_LF);
   endtask

   task automatic send_line_q();
      foreach (line_q[i]) send_item(lhf_pkg::KIND_BYTE, line_q[i]);
   endtask

   task automatic write_reg(input logic [lhf_pkg::CSR_INDEX_W-1:0] index,
                            input logic [lhf_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Lets every expected result arrive and the block go quiet.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (chk_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
         1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
         default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
   endtask

   // New pattern text, length and target for one phase.
   task automatic load_settings(input int phase);
      logic [lhf_pkg::CSR_DATA_W-1:0]    words [lhf_pkg::PATTERN_WORDS];
      logic [lhf_pkg::PATTERN_LEN_W-1:0] len;
      int k;
      case (phase)
         0: begin len = 6'd4;  target_now = 8'($urandom); end
         1: begin len = 6'd1;  target_now = 8'h00;        end
         2: begin len = 6'd32; target_now = 8'hFF;        end
         3: begin len = 6'd7;  target_now = 8'($urandom); end
         4: begin len = 6'd63; target_now = 8'h00;        end
         5: begin len = 6'd16; target_now = 8'($urandom); end
         6: begin len = 6'd2;  target_now = 8'hFF;        end
         default: begin len = 6'd32; target_now = 8'($urandom); end
      endcase
      for (k = 0; k < lhf_pkg::PATTERN_CHARS; k++) begin
         pat_chars[k] = random_text_char();
         words[k / 8][8 * (k % 8) +: 8] = pat_chars[k];
      end
      write_reg(lhf_pkg::REG_PATTERN_WORD0, words[0]);
      write_reg(lhf_pkg::REG_PATTERN_WORD1, words[1]);
      write_reg(lhf_pkg::REG_PATTERN_WORD2, words[2]);
      write_reg(lhf_pkg::REG_PATTERN_WORD3, words[3]);
      write_reg(lhf_pkg::REG_PATTERN_LENGTH, csr_word_type'(len));
      write_reg(lhf_pkg::REG_TARGET_PROPERTY, csr_word_type'(target_now));
      if (phase == 0) begin
         write_reg(REG_SPARE6, {$urandom, $urandom});
         write_reg(REG_SPARE7, {$urandom, $urandom});
      end
      csr_write_enable <= 1'b0;
      pat_use = (len > lhf_pkg::PATTERN_CHARS) ? lhf_pkg::PATTERN_CHARS : int'(len);
   endtask

   task automatic add_pattern();
      int k;
      for (k = 0; k < pat_use; k++) line_q.push_back(pat_chars[k]);
   endtask

   // Record: text, pattern?, comma, handle, comma, property, pattern?, text.
   task automatic build_record(input bit truncate);
      int n;
      int k;
      int spot;
      int cut;
      logic [lhf_pkg::HANDLE_W-1:0]   handle;
      logic [lhf_pkg::PROPERTY_W-1:0] prop;
      line_q.delete();
      spot = $urandom_range(9);
      n    = $urandom_range(5);
      repeat (n) line_q.push_back(random_text_char());
      if (spot >= 1 && spot <= 6) add_pattern();
      line_q.push_back(lhf_pkg::CHAR_COMMA);
      handle = 16'($urandom);
      for (k = 3; k >= 0; k--) line_q.push_back(hex_char(handle[4 * k +: 4]));
      if ($urandom_range(9) == 0) line_q[line_q.size() - 1 - $urandom_range(3)] = non_hex_char();
      line_q.push_back(lhf_pkg::CHAR_COMMA);
      prop = ($urandom_range(99) < 65) ? target_now : 8'($urandom);
      line_q.push_back(hex_char(prop[7:4]));
      line_q.push_back(hex_char(prop[3:0]));
      if ($urandom_range(9) == 0) line_q[line_q.size() - 1 - $urandom_range(1)] = non_hex_char();
      if (spot >= 7) add_pattern();
      n = $urandom_range(4);
      repeat (n) line_q.push_back(random_text_char());
      if (truncate) begin
         cut = $urandom_range(line_q.size() - 1);
         while (line_q.size() > cut) void'(line_q.pop_back());
      end
      // Occasional dropped byte or lone carriage return inside the line.
      if ($urandom_range(9) == 0) begin
         line_q.insert($urandom_range(line_q.size()),
                       $urandom_range(1) ? lhf_pkg::CHAR_NUL : lhf_pkg::CHAR_DEL);
      end
      if ($urandom_range(19) == 0 && line_q.size() > 0) begin
         line_q.insert($urandom_range(line_q.size() - 1), lhf_pkg::CHAR_CR);
      end
   endtask

   task automatic build_noise();
      int n;
      line_q.delete();
      n = $urandom_range(12);
      repeat (n) line_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(4) == 0) line_q.insert($urandom_range(line_q.size()), lhf_pkg::CHAR_LF);
      if ($urandom_range(4) == 0) line_q.insert($urandom_range(line_q.size()), lhf_pkg::CHAR_CR);
   endtask

   // One listing: a few lines, then the END line or a flush.
   task automatic send_listing();
      int lines;
      int pick;
      int target_len;
      bit crlf;
      lines = $urandom_range(1, 4);
      repeat (lines) begin
         pick = $urandom_range(99);
         crlf = 1'b1;
         if (pick < 62) begin
            build_record(1'b0);
         end else if (pick < 80) begin
            build_record(1'b1);
         end else if (pick < 94) begin
            build_noise();
            crlf = ($urandom_range(9) >= 3);
         end else begin
            // Record followed by padding that can run past the line buffer.
            build_record(1'b0);
            target_len = $urandom_range(124, 140);
            while (line_q.size() < target_len) line_q.push_back(random_text_char());
         end
         send_line_q();
         if (crlf) send_crlf();
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
         send_text("END");
         send_crlf();
      end else if (pick < 90) begin
         send_item(lhf_pkg::KIND_FLUSH, 8'($urandom));
      end else begin
         build_record(1'b1);
         send_line_q();
         send_item(lhf_pkg::KIND_FLUSH, 8'($urandom));
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int phase;
      int first_item;
      int listings;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.kind      <= lhf_pkg::KIND_BYTE;
      req_chan.data_byte <= '0;
      csr_write_enable   <= 1'b0;
      csr_index          <= lhf_pkg::REG_PATTERN_WORD0;
      csr_write_data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: the all-zero pattern never matches. The line also
      // carries dropped bytes and ends on a doubled carriage return.
      send_text(",12");
      send_item(lhf_pkg::KIND_BYTE, lhf_pkg::CHAR_NUL);
      send_text("34,0");
      send_item(lhf_pkg::KIND_BYTE, lhf_pkg::CHAR_DEL);
      send_text("0");
      send_item(lhf_pkg::KIND_BYTE, lhf_pkg::CHAR_CR);
      send_crlf();
      send_item(lhf_pkg::KIND_FLUSH, 8'hA5);
      settle();

      // Empty pattern matches any line: END closes an empty listing, then a
      // maximal handle is kept and a partial END line is flushed.
      write_reg(lhf_pkg::REG_PATTERN_LENGTH, '0);
      csr_write_enable <= 1'b0;
      send_text("END");
      send_crlf();
      send_text(",FfFf,00");
      send_crlf();
      send_text("END");
      send_item(lhf_pkg::KIND_FLUSH, 8'h5A);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         set_idle(phase % 4);
         load_settings(phase);
         if (phase == 4) begin
            // Hold the result side off so results back up and stall input.
            hold_request = HOLD_CYCLES;
            repeat (8) send_item(lhf_pkg::KIND_FLUSH, 8'($urandom));
         end
         first_item = items_sent;
         listings   = 0;
         while (items_sent - first_item < PHASE_ITEMS || listings < PHASE_LISTINGS) begin
            send_listing();
            listings++;
         end
         send_item(lhf_pkg::KIND_FLUSH, 8'($urandom));
         settle();
      end

      $display("tb: %0d items, %0d listings closed by END and %0d by flush, %0d with a handle",
               items_sent, chk_end, chk_flush, chk_found);
      $display("tb: pattern lengths 0 to 63, targets 0 to 255, gaps, stalls and a long hold");
      if (chk_errors == 0 && chk_pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
